@@ src/lcdnw_pkg.sv @@
// Shared types, codes and lookup functions for the character LCD nibble writer.
package lcdnw_pkg;

    // Command codes carried on the input channel.
    localparam logic [2:0] CMD_INIT    = 3'd0;
    localparam logic [2:0] CMD_REFRESH = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_RAW     = 3'd3;
    localparam logic [2:0] CMD_CURSOR  = 3'd4;
    localparam logic [2:0] CMD_DECIMAL = 3'd5;
    localparam logic [2:0] CMD_HEX     = 3'd6;
    localparam logic [2:0] CMD_NONE    = 3'd7;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Instruction bytes and fixed nibbles.
    localparam logic [3:0] INIT_NIBBLE   = 4'h2;
    localparam logic [7:0] INS_FUNC_SET  = 8'h28;
    localparam logic [7:0] INS_DISP_ON   = 8'h0C;
    localparam logic [7:0] INS_ENTRY     = 8'h06;
    localparam logic [7:0] INS_CLEAR     = 8'h01;
    localparam logic [7:0] INS_HOME      = 8'h02;
    localparam logic [7:0] INS_DDRAM     = 8'h80;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_HEX_OFS = 8'h37;

    // Index of the units position in the decimal power table.
    localparam logic [2:0] POW_UNITS = 3'd4;

    // Operation classes handed from front to back.
    typedef enum logic [2:0] {
        OP_INIT    = 3'd0,
        OP_REFRESH = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_BYTE    = 3'd3,
        OP_DEC     = 3'd4,
        OP_HEX     = 3'd5
    } op_t;

    // One classified command as it sits in the queue.
    typedef struct packed {
        op_t         op;
        logic [7:0]  byte_val;
        logic        rs;
        logic [15:0] number;
    } desc_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Queue push and pop strobes.
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    // Setup sequence byte at a given position.
    function automatic logic [7:0] setup_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = INS_FUNC_SET;
            2'd1:    b = INS_DISP_ON;
            default: b = INS_ENTRY;
        endcase
        return b;
    endfunction

    // Uppercase ASCII hex digit.
    function automatic logic [7:0] hex_ascii(input logic [3:0] d);
        logic [7:0] b;
        if (d < 4'd10) begin
            b = ASCII_ZERO + {4'b0, d};
        end else begin
            b = ASCII_HEX_OFS + {4'b0, d};
        end
        return b;
    endfunction

    // Decimal weight of each digit position, most significant first.
    function automatic logic [13:0] pow10(input logic [2:0] idx);
        logic [13:0] p;
        case (idx)
            3'd0:    p = 14'd10000;
            3'd1:    p = 14'd1000;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd10;
            default: p = 14'd1;
        endcase
        return p;
    endfunction

endpackage

@@ src/lcdnw_front.sv @@
// Front part: accepts command beats, classifies them and pushes them into the queue.
module lcdnw_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [2:0]        cmd,
    input  logic [7:0]        byte_value,
    input  logic              is_data,
    input  logic              row,
    input  logic [5:0]        col,
    input  logic [15:0]       number,
    input  lcdnw_pkg::q_stat_t q_stat,
    output logic              push,
    output lcdnw_pkg::desc_t  desc
);

    logic known_cmd;

    // Map each command onto an operation class and its byte and RS level.
    always_comb begin
        known_cmd     = 1'b1;
        desc.op       = lcdnw_pkg::OP_BYTE;
        desc.byte_val = byte_value;
        desc.rs       = 1'b0;
        desc.number   = number;
        case (cmd)
            lcdnw_pkg::CMD_INIT:    desc.op = lcdnw_pkg::OP_INIT;
            lcdnw_pkg::CMD_REFRESH: desc.op = lcdnw_pkg::OP_REFRESH;
            lcdnw_pkg::CMD_CLEAR:   desc.op = lcdnw_pkg::OP_CLEAR;
            lcdnw_pkg::CMD_RAW: begin
                desc.op = lcdnw_pkg::OP_BYTE;
                desc.rs = is_data;
            end
            lcdnw_pkg::CMD_CURSOR: begin
                desc.op       = lcdnw_pkg::OP_BYTE;
                desc.byte_val = lcdnw_pkg::INS_DDRAM
                              | (row ? lcdnw_pkg::ROW1_OFFSET : 8'h00)
                              | {2'b00, col};
            end
            lcdnw_pkg::CMD_DECIMAL: begin
                desc.op = lcdnw_pkg::OP_DEC;
                desc.rs = 1'b1;
            end
            lcdnw_pkg::CMD_HEX: begin
                desc.op = lcdnw_pkg::OP_HEX;
                desc.rs = 1'b1;
            end
            default: known_cmd = 1'b0;
        endcase
    end

    // The unused command code is taken and dropped, since it writes nothing.
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready && known_cmd;

endmodule

@@ src/lcdnw_queue.sv @@
// Short first-in first-out queue of classified commands between front and back.
module lcdnw_queue #(
    parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcdnw_pkg::q_ctl_t  q_ctl,
    input  lcdnw_pkg::desc_t   wr_desc,
    output lcdnw_pkg::desc_t   rd_desc,
    output lcdnw_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdnw_pkg::desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer advance with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    // Next pointers and fill count.
    always_comb begin
        wr_ptr_next = q_ctl.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = q_ctl.pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_ctl.push && !q_ctl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!q_ctl.push && q_ctl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (q_ctl.push) begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    assign rd_desc      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

@@ src/lcdnw_back.sv @@
// Back part: sequences the nibble writes of one command into an output register.
module lcdnw_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  lcdnw_pkg::desc_t   q_desc,
    input  lcdnw_pkg::q_stat_t q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [3:0]         m_nibble,
    output logic               m_rs,
    output logic               m_last
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LONE = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_HI   = 5'b01000,
        ST_LO   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    lcdnw_pkg::desc_t desc_reg, desc_next;
    logic [1:0]       idx_reg, idx_next;
    logic [2:0]       pow_reg, pow_next;
    logic [3:0]       digit_reg, digit_next;
    logic [15:0]      rem_reg, rem_next;
    logic             started_reg, started_next;
    logic             m_valid_reg, m_valid_next;
    logic [3:0]       m_nibble_reg, m_nibble_next;
    logic             m_rs_reg, m_rs_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             out_load;
    logic [7:0]       cur_byte;
    logic             cur_last;
    logic [3:0]       hex_sel;
    logic [15:0]      weight;

    assign out_free = !m_valid_reg || m_tready;
    assign weight   = {2'b00, lcdnw_pkg::pow10(pow_reg)};

    // Byte at the current position and whether it closes the command.
    always_comb begin
        case (idx_reg)
            2'd0:    hex_sel = desc_reg.number[11:8];
            2'd1:    hex_sel = desc_reg.number[7:4];
            default: hex_sel = desc_reg.number[3:0];
        endcase
        case (desc_reg.op)
            lcdnw_pkg::OP_INIT, lcdnw_pkg::OP_REFRESH: begin
                cur_byte = lcdnw_pkg::setup_byte(idx_reg);
                cur_last = (idx_reg == 2'd2);
            end
            lcdnw_pkg::OP_CLEAR: begin
                cur_byte = (idx_reg == 2'd0) ? lcdnw_pkg::INS_CLEAR : lcdnw_pkg::INS_HOME;
                cur_last = (idx_reg == 2'd1);
            end
            lcdnw_pkg::OP_HEX: begin
                cur_byte = lcdnw_pkg::hex_ascii(hex_sel);
                cur_last = (idx_reg == 2'd2);
            end
            lcdnw_pkg::OP_DEC: begin
                cur_byte = lcdnw_pkg::ASCII_ZERO | {4'b0, digit_reg};
                cur_last = (pow_reg == lcdnw_pkg::POW_UNITS);
            end
            default: begin
                cur_byte = desc_reg.byte_val;
                cur_last = 1'b1;
            end
        endcase
    end

    // Sequencer: at most one nibble per free output slot, digits by repeated subtraction.
    always_comb begin
        state_next    = state_reg;
        desc_next     = desc_reg;
        idx_next      = idx_reg;
        pow_next      = pow_reg;
        digit_next    = digit_reg;
        rem_next      = rem_reg;
        started_next  = started_reg;
        pop           = 1'b0;
        out_load      = 1'b0;
        m_nibble_next = m_nibble_reg;
        m_rs_next     = m_rs_reg;
        m_last_next   = m_last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    pop          = 1'b1;
                    desc_next    = q_desc;
                    idx_next     = 2'd0;
                    pow_next     = 3'd0;
                    digit_next   = 4'd0;
                    started_next = 1'b0;
                    rem_next     = q_desc.number;
                    case (q_desc.op)
                        lcdnw_pkg::OP_INIT: state_next = ST_LONE;
                        lcdnw_pkg::OP_DEC:  state_next = ST_DIV;
                        default:            state_next = ST_HI;
                    endcase
                end
            end
            ST_LONE: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_nibble_next = lcdnw_pkg::INIT_NIBBLE;
                    m_rs_next     = 1'b0;
                    m_last_next   = 1'b0;
                    state_next    = ST_HI;
                end
            end
            ST_DIV: begin
                if (pow_reg == lcdnw_pkg::POW_UNITS) begin
                    // The remainder is below ten here.
                    digit_next = rem_reg[3:0];
                    state_next = ST_HI;
                end else if (rem_reg >= weight) begin
                    rem_next   = rem_reg - weight;
                    digit_next = digit_reg + 1'b1;
                end else if (digit_reg != 4'd0 || started_reg) begin
                    started_next = 1'b1;
                    state_next   = ST_HI;
                end else begin
                    // Leading zero: skip this position.
                    pow_next = pow_reg + 1'b1;
                end
            end
            ST_HI: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_nibble_next = cur_byte[7:4];
                    m_rs_next     = desc_reg.rs;
                    m_last_next   = 1'b0;
                    state_next    = ST_LO;
                end
            end
            ST_LO: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    m_nibble_next = cur_byte[3:0];
                    m_rs_next     = desc_reg.rs;
                    m_last_next   = cur_last;
                    if (cur_last) begin
                        state_next = ST_IDLE;
                    end else if (desc_reg.op == lcdnw_pkg::OP_DEC) begin
                        pow_next   = pow_reg + 1'b1;
                        digit_next = 4'd0;
                        state_next = ST_DIV;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_HI;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        desc_reg     <= desc_next;
        idx_reg      <= idx_next;
        pow_reg      <= pow_next;
        digit_reg    <= digit_next;
        rem_reg      <= rem_next;
        started_reg  <= started_next;
        m_nibble_reg <= m_nibble_next;
        m_rs_reg     <= m_rs_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_nibble = m_nibble_reg;
    assign m_rs     = m_rs_reg;
    assign m_last   = m_last_reg;

endmodule

@@ src/char_lcd_nibble_writer_core.sv @@
// Top level of the character LCD nibble writer: front, command queue and back.
//
// Usage: each beat on the s_ channel is one LCD command (init, refresh, clear,
// raw byte, set cursor, decimal, hex). The m_ channel returns the nibble writes
// the command causes, high nibble first, with the RS level in m_tuser and
// m_tlast on the final nibble of each command. The unused command code is taken
// and writes nothing.
// An accepted command passes the queue entry and the back's command register
// before it reaches the output register. Init writes an init nibble and three
// setup bytes, refresh three setup bytes, clear a clear and a home byte, raw
// byte and set cursor one byte, hex three digits. Decimal skips leading zeros
// and finds each digit by repeated subtraction in the shared compare step.
// The front accepts a new command every cycle while the queue of QUEUE_DEPTH
// entries has room, so it keeps taking commands while the back works.
// When the receiver stalls, the output register holds its beat and the back
// waits; the queue then fills and s_tready drops.
// Reset (aresetn low, synchronous) empties the queue and the output register.
module char_lcd_nibble_writer_core #(
    parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // byte_value[7:0], row[8], col[14:9], number[30:15], zero[31]
    input  logic [3:0]  s_tuser,  // cmd[2:0], is_data[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // nibble[3:0], zero[7:4]
    output logic        m_tuser,  // reg_select[0]
    output logic        m_tlast
);

    lcdnw_pkg::desc_t   front_desc;
    lcdnw_pkg::desc_t   queue_desc;
    lcdnw_pkg::q_stat_t q_stat;
    lcdnw_pkg::q_ctl_t  q_ctl;
    logic               push;
    logic               pop;
    logic [3:0]         nibble;

    // Accept and classify.
    lcdnw_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .cmd        (s_tuser[2:0]),
        .byte_value (s_tdata[7:0]),
        .is_data    (s_tuser[3]),
        .row        (s_tdata[8]),
        .col        (s_tdata[14:9]),
        .number     (s_tdata[30:15]),
        .q_stat     (q_stat),
        .push       (push),
        .desc       (front_desc)
    );

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    // Command queue.
    lcdnw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_ctl   (q_ctl),
        .wr_desc (front_desc),
        .rd_desc (queue_desc),
        .q_stat  (q_stat)
    );

    // Nibble sequencer and output register.
    lcdnw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_desc   (queue_desc),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_nibble (nibble),
        .m_rs     (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, nibble};

`ifndef NO_ASSERTIONS
    // The back never pops an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_ctl.pop |-> !q_stat.empty)
        else $error("pop from empty command queue");

    // The front never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_ctl.push |-> !q_stat.full)
        else $error("push into full command queue");

    // Every accepted known command enters the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[2:0] != lcdnw_pkg::CMD_NONE)) |-> q_ctl.push)
        else $error("accepted command was not queued");

    // A queue that was full and saw no pop is still full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.full && !q_ctl.pop) |=> q_stat.full)
        else $error("full queue lost an entry without a pop");
`endif

endmodule
